### src/rcmd_pkg.sv
// Shared constants and register index codes for the RC channel mixer.
package rcmd_pkg;

  // Width of the output span operand (2 * drive_range or throttle_range)
  localparam int RANGE_BITS = 16;

  typedef enum logic [2:0] {
    CFG_LIM_LOW        = 3'd0,
    CFG_LIM_HIGH       = 3'd1,
    CFG_STICK_DB       = 3'd2,
    CFG_DRIVE_RANGE    = 3'd3,
    CFG_THROTTLE_RANGE = 3'd4,
    CFG_DRIVE_DEADBAND = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic       chan_valid;
    logic [2:0] neg;
  } sideband_t;

endpackage

### src/rc_channel_mixer_deadband.sv
// Top level: differential RC mixer with stick deadband and drive gate.
//
// Input stream (s_*): one beat carries the aileron, elevator and throttle
// pulse widths in tdata and the channels-valid flag in tuser. Output
// stream (m_*): one beat per input beat with left speed, right speed and
// throttle width. Configuration: cfg_we / cfg_index / cfg_data write one
// register per clock; write only while no beat is in flight.
//
// Pipeline: front stage (centering, deadband, span), multiply stage, then
// one division cell per quotient bit (PULSE_BITS + 16 cells), a mapping
// and clamp stage and the output register that mixes and gates.
// One beat is accepted every cycle while the receiver does not stall the output.
//
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults. When the receiver holds m_tready low with a beat waiting, the
// whole pipeline freezes and s_tready drops in the same cycle; no beat is
// dropped and beats in flight simply wait in their stages.
module rc_channel_mixer_deadband #(
  parameter int PULSE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // config port
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [((PULSE_BITS > 16) ? PULSE_BITS : 16)-1:0] cfg_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // aileron_width, elevator_width, throttle_width (PULSE_BITS each), zero pad
  input  logic [((3*PULSE_BITS+7)/8)*8-1:0] s_tdata,
  // channels_valid
  input  logic                  s_tuser,
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // left_speed, right_speed, throttle_out (16 bits each)
  output logic [47:0]           m_tdata
);

  localparam int P     = PULSE_BITS;
  localparam int RB    = rcmd_pkg::RANGE_BITS;
  localparam int N     = P + RB;            // product / quotient width
  localparam int CB    = ((P > 14) ? P : 14) + 3; // centered value width
  localparam int VW    = N + 3;             // mapped value width
  localparam int LAST  = N + 3;             // index of output stage valid

  // ---------------- configuration registers ----------------
  logic [P-1:0]  lim_low, lim_high;
  logic [13:0]   stick_db;
  logic [14:0]   drive_range;
  logic [15:0]   throttle_range;
  logic [14:0]   drive_deadband;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_low        <= P'(1000);
      lim_high       <= P'(2000);
      stick_db       <= 14'd20;
      drive_range    <= 15'd1000;
      throttle_range <= 16'd1000;
      drive_deadband <= 15'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcmd_pkg::CFG_LIM_LOW:        lim_low        <= cfg_data[P-1:0];
        rcmd_pkg::CFG_LIM_HIGH:       lim_high       <= cfg_data[P-1:0];
        rcmd_pkg::CFG_STICK_DB:       stick_db       <= cfg_data[13:0];
        rcmd_pkg::CFG_DRIVE_RANGE:    drive_range    <= cfg_data[14:0];
        rcmd_pkg::CFG_THROTTLE_RANGE: throttle_range <= cfg_data[15:0];
        rcmd_pkg::CFG_DRIVE_DEADBAND: drive_deadband <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [LAST:0] vld;
  logic          en;

  assign en       = !vld[LAST] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], s_tvalid};
    end
  end

  // ---------------- front stage: center, deadband ----------------
  // Config must stay static while beats are in flight (the block does not enforce it); later stages use it live.
  logic [P:0]           lim_sum;
  logic signed [CB-1:0] center_in;
  logic signed [CB-1:0] dead_s;
  logic signed [CB-1:0] span_stick, span_thr;
  logic                 spok_stick, spok_thr;
  logic [P-1:0]         div_stick, div_thr;

  logic [P-1:0]         w_in [0:2];
  logic signed [CB-1:0] c    [0:2];
  logic signed [CB-1:0] cmag [0:2];
  logic signed [CB-1:0] dch  [0:2];
  logic [P-1:0]         m_next [0:2];
  logic [2:0]           neg_next;

  always_comb begin
    lim_sum    = {1'b0, lim_low} + {1'b0, lim_high};
    center_in  = $signed(CB'(lim_sum[P:1]));
    dead_s     = $signed(CB'(stick_db));
    span_thr   = $signed(CB'(lim_high)) - $signed(CB'(lim_low));
    span_stick = span_thr - (dead_s <<< 1);
    spok_thr   = span_thr > 0;
    spok_stick = span_stick > 0;
    div_thr    = span_thr[P-1:0];
    div_stick  = span_stick[P-1:0];
    for (int ch = 0; ch < 3; ch++) begin
      w_in[ch] = s_tdata[ch*P +: P];
      dch[ch]  = (ch < 2) ? dead_s : '0;
      c[ch]    = $signed(CB'(w_in[ch])) - center_in;
      cmag[ch] = (c[ch] < 0) ? -c[ch] : c[ch];
      neg_next[ch] = c[ch] < 0;
      if (cmag[ch] <= dch[ch]) begin
        m_next[ch] = '0;
      end else begin
        m_next[ch] = P'(cmag[ch] - dch[ch]);
      end
    end
  end

  // sideband shift line follows the data
  rcmd_pkg::sideband_t sb [0:N+2];
  logic [P-1:0]        mag  [0:2];
  logic [N-1:0]        prod [0:2];
  logic [N-1:0]        quo  [0:2];
  logic [RB-1:0]       rng  [0:2];

  always_comb begin
    rng[0] = {drive_range, 1'b0};
    rng[1] = {drive_range, 1'b0};
    rng[2] = throttle_range;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= '{chan_valid: s_tuser, neg: neg_next};
      for (int i = 1; i <= N + 2; i++) begin
        sb[i] <= sb[i-1];
      end
      for (int ch = 0; ch < 3; ch++) begin
        mag[ch]  <= m_next[ch];
        prod[ch] <= N'(mag[ch]) * N'(rng[ch]);
      end
    end
  end

  // ---------------- divider rows ----------------
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    rcmd_div_chain #(
      .DIV_BITS (P)
    ) u_chain (
      .clk     (clk),
      .en      (en),
      .divisor ((ch < 2) ? div_stick : div_thr),
      .num_in  (prod[ch]),
      .quo_out (quo[ch])
    );
  end

  // ---------------- map and clamp ----------------
  logic signed [VW-1:0] rs, ts, tc;
  logic signed [VW-1:0] val [0:2];
  logic signed [VW-1:0] vc  [0:2];
  logic signed [15:0]   ail, ele;
  logic [15:0]          thr;

  always_comb begin
    rs = $signed(VW'(drive_range));
    ts = $signed(VW'(throttle_range));
    tc = ts >>> 1;
    for (int ch = 0; ch < 3; ch++) begin
      val[ch] = sb[N+1].neg[ch] ? -$signed(VW'(quo[ch])) : $signed(VW'(quo[ch]));
    end
    // sticks: center zero, clamp to +-drive_range
    for (int ch = 0; ch < 2; ch++) begin
      vc[ch] = spok_stick ? val[ch] : '0;
      if (vc[ch] > rs) vc[ch] = rs;
      if (vc[ch] < -rs) vc[ch] = -rs;
    end
    // throttle: center at half scale, clamp to [0, throttle_range]
    vc[2] = spok_thr ? (val[2] + tc) : tc;
    if (vc[2] > ts) vc[2] = ts;
    if (vc[2] < 0) vc[2] = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ail <= vc[0][15:0];
      ele <= vc[1][15:0];
      thr <= vc[2][15:0];
    end
  end

  // ---------------- mix, gate, output register ----------------
  logic signed [16:0] r17, dd17;
  logic signed [16:0] mix [0:1];
  logic signed [16:0] mag17 [0:1];
  logic [15:0]        spd [0:1];

  always_comb begin
    r17  = $signed({2'b00, drive_range});
    dd17 = $signed({2'b00, drive_deadband});
    mix[0] = {ele[15], ele} - {ail[15], ail};
    mix[1] = {ele[15], ele} + {ail[15], ail};
    for (int k = 0; k < 2; k++) begin
      if (mix[k] > r17) mix[k] = r17;
      if (mix[k] < -r17) mix[k] = -r17;
      mag17[k] = (mix[k] < 0) ? -mix[k] : mix[k];
      spd[k]   = (mag17[k] > dd17) ? mix[k][15:0] : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sb[N+2].chan_valid) begin
        m_tdata <= {thr, spd[1], spd[0]};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

### src/rcmd_div_cell.sv
// One restoring-division step: one quotient bit per cell, registered.
module rcmd_div_cell #(
  parameter int DIV_BITS = 16,
  parameter int NUM_BITS = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DIV_BITS-1:0] divisor,
  input  logic [DIV_BITS-1:0] rem_in,
  input  logic [NUM_BITS-1:0] num_in,
  input  logic [NUM_BITS-1:0] quo_in,
  output logic [DIV_BITS-1:0] rem_out,
  output logic [NUM_BITS-1:0] num_out,
  output logic [NUM_BITS-1:0] quo_out
);

  logic [DIV_BITS:0] trial;
  logic [DIV_BITS:0] diff;
  logic              ge;

  always_comb begin
    trial = {rem_in, num_in[NUM_BITS-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      num_out <= {num_in[NUM_BITS-2:0], 1'b0};
      quo_out <= {quo_in[NUM_BITS-2:0], ge};
    end
  end

endmodule

### src/rcmd_div_chain.sv
// Row of division cells, one per quotient bit: unsigned quotient.
module rcmd_div_chain #(
  parameter int DIV_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [DIV_BITS-1:0]                        divisor,
  input  logic [DIV_BITS+rcmd_pkg::RANGE_BITS-1:0]   num_in,
  output logic [DIV_BITS+rcmd_pkg::RANGE_BITS-1:0]   quo_out
);

  localparam int NUM_BITS = DIV_BITS + rcmd_pkg::RANGE_BITS;

  logic [DIV_BITS-1:0] rem [0:NUM_BITS];
  logic [NUM_BITS-1:0] num [0:NUM_BITS];
  logic [NUM_BITS-1:0] quo [0:NUM_BITS];

  assign rem[0] = '0;
  assign num[0] = num_in;
  assign quo[0] = '0;

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
    rcmd_div_cell #(
      .DIV_BITS (DIV_BITS),
      .NUM_BITS (NUM_BITS)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .divisor (divisor),
      .rem_in  (rem[k]),
      .num_in  (num[k]),
      .quo_in  (quo[k]),
      .rem_out (rem[k+1]),
      .num_out (num[k+1]),
      .quo_out (quo[k+1])
    );
  end

  assign quo_out = quo[NUM_BITS];

endmodule

### tb/tb.sv
// Self-checking testbench for the RC channel mixer with deadband.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the register list; the block must ignore writes to it.
  localparam logic [2:0] CFG_UNUSED = 3'd6;
  localparam int LATENCY = 36;

  // left speed in the low bits, as on m_tdata
  typedef struct packed {
    logic [15:0] throttle;
    logic [15:0] right;
    logic [15:0] left;
  } mix_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // aileron, elevator, throttle widths from bit 0 up
  logic        s_tuser = 1'b0; // channels_valid
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // left, right, throttle from bit 0 up

  // Our own copy of the register file
  logic [15:0] pw_low, pw_high, out_thr_range;
  logic [13:0] stick_dead;
  logic [14:0] drv_range, drv_dead;

  mix_out_t mix_expected[$];
  int errors = 0;
  int hold_left = 0;   // long receiver hold-off, counted down by the receiver
  int stall_left = 0;
  bit calm = 1'b0;     // no random idling on either side while set

  rc_channel_mixer_deadband dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  task automatic flag(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Maps one pulse width onto [lo_o, hi_o] around the input center.
  function automatic longint map_pulse(longint w, longint lo_o, longint hi_o,
                                       longint dead);
    longint c, span, v;
    c = w - (longint'(pw_low) + longint'(pw_high)) / 2;
    span = longint'(pw_high) - longint'(pw_low) - 2 * dead;
    if (c <= dead && c >= -dead) c = 0;
    else if (c > 0) c -= dead;
    else c += dead;
    if (span <= 0) v = (lo_o + hi_o) / 2;
    else v = c * (hi_o - lo_o) / span + (lo_o + hi_o) / 2;
    if (v > hi_o) v = hi_o;
    if (v < lo_o) v = lo_o;
    return v;
  endfunction

  function automatic longint gate_drive(longint v, longint r);
    longint mag;
    if (v > r) v = r;
    if (v < -r) v = -r;
    mag = v < 0 ? -v : v;
    return mag > longint'(drv_dead) ? v : 0;
  endfunction

  function automatic mix_out_t mix_predict(logic [15:0] ail, logic [15:0] ele,
                                           logic [15:0] thr, logic ok);
    mix_out_t o;
    longint r, a, e;
    o = '0;
    if (ok) begin
      r = longint'(drv_range);
      a = map_pulse(ail, -r, r, stick_dead);
      e = map_pulse(ele, -r, r, stick_dead);
      o.left = 16'(gate_drive(e - a, r));
      o.right = 16'(gate_drive(e + a, r));
      o.throttle = 16'(map_pulse(thr, 0, out_thr_range, 0));
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one beat; valid stays high after acceptance unless a gap follows.
  task automatic send_beat(input logic [15:0] ail, ele, thr, input logic ok);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {thr, ele, ail};
    s_tuser <= ok;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mix_expected.push_back(mix_predict(ail, ele, thr, ok));
  endtask

  // Sender pause: wait for every result plus the pipeline depth.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Register write; write enable is lowered by the caller (cfg_all).
  task automatic cfg_put(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      rcmd_pkg::CFG_LIM_LOW:        pw_low = val;
      rcmd_pkg::CFG_LIM_HIGH:       pw_high = val;
      rcmd_pkg::CFG_STICK_DB:       stick_dead = val[13:0];
      rcmd_pkg::CFG_DRIVE_RANGE:    drv_range = val[14:0];
      rcmd_pkg::CFG_THROTTLE_RANGE: out_thr_range = val;
      rcmd_pkg::CFG_DRIVE_DEADBAND: drv_dead = val[14:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [15:0] lo, hi, dead, rng, thr, ddead);
    cfg_put(rcmd_pkg::CFG_LIM_LOW, lo);
    cfg_put(rcmd_pkg::CFG_LIM_HIGH, hi);
    cfg_put(rcmd_pkg::CFG_STICK_DB, dead);
    cfg_put(rcmd_pkg::CFG_DRIVE_RANGE, rng);
    cfg_put(rcmd_pkg::CFG_THROTTLE_RANGE, thr);
    cfg_put(rcmd_pkg::CFG_DRIVE_DEADBAND, ddead);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly around the configured window and the deadband, some anywhere.
  function automatic logic [15:0] pick_width();
    int r, lo_w, hi_w, mid, d;
    r = $urandom_range(99);
    lo_w = int'(pw_low) - 300;
    hi_w = int'(pw_high) + 300;
    if (lo_w < 0) lo_w = 0;
    if (hi_w > 65535) hi_w = 65535;
    mid = (int'(pw_low) + int'(pw_high)) / 2;
    d = int'(stick_dead) + 5;
    if (r < 55) return 16'($urandom_range(hi_w, lo_w));
    if (r < 80) begin
      lo_w = mid - d < 0 ? 0 : mid - d;
      hi_w = mid + d > 65535 ? 65535 : mid + d;
      return 16'($urandom_range(hi_w, lo_w));
    end
    return 16'($urandom);
  endfunction

  task automatic random_beats(input int n);
    repeat (n) send_beat(pick_width(), pick_width(), pick_width(),
                         $urandom_range(9) != 0);
  endtask

  // Receiver: random stalls, a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(99) < 15) begin
      m_tready <= 1'b0;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                              : $urandom_range(2, 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker: oldest expectation against each output beat.
  always @(posedge clk) begin
    mix_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (mix_expected.size() == 0) begin
        flag($sformatf("unexpected beat %h", m_tdata));
      end else begin
        want = mix_expected.pop_front();
        if (got.left !== want.left)
          flag($sformatf("left %h, want %h", got.left, want.left));
        if (got.right !== want.right)
          flag($sformatf("right %h, want %h", got.right, want.right));
        if (got.throttle !== want.throttle)
          flag($sformatf("throttle %h, want %h", got.throttle, want.throttle));
      end
    end
  end

  // Reset defaults, field extremes, deadband edges, invalid channels.
  task automatic test_directed();
    send_beat(16'd1500, 16'd1500, 16'd1500, 1'b1);
    send_beat(16'd0, 16'd0, 16'd0, 1'b1);
    send_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_beat(16'd1000, 16'd2000, 16'd1000, 1'b1);
    send_beat(16'd2000, 16'd1000, 16'd2000, 1'b1);
    send_beat(16'd1520, 16'd1480, 16'd1250, 1'b1);  // edge of the deadband
    send_beat(16'd1521, 16'd1479, 16'd1750, 1'b1);  // just outside it
    send_beat(16'd1560, 16'd1500, 16'd1500, 1'b1);  // over the drive gate
    send_beat(16'd1580, 16'd1580, 16'd1999, 1'b1);
    send_beat(16'd1400, 16'd1600, 16'd1001, 1'b1);
    send_beat(16'hFFFF, 16'd0, 16'hAAAA, 1'b1);
    send_beat(16'd0, 16'hFFFF, 16'h5555, 1'b1);
    send_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);  // invalid: all zero
    send_beat(16'd1800, 16'd1200, 16'd1700, 1'b0);
    send_beat(16'd1100, 16'd1900, 16'd900, 1'b1);
    drain();
  endtask

  // Extreme and odd register settings, each followed by some beats.
  task automatic test_config_edges();
    cfg_all(16'd0, 16'hFFFF, 16'h3FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF);
    random_beats(40);
    drain();
    cfg_all(16'd0, 16'hFFFF, 16'd0, 16'h7FFF, 16'hFFFF, 16'd0);
    send_beat(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    send_beat(16'hFFFF, 16'd0, 16'd0, 1'b1);
    random_beats(40);
    drain();
    // span not positive: reversed limits, then deadband eating the span
    cfg_all(16'd2000, 16'd1000, 16'd20, 16'd1000, 16'd999, 16'd0);
    random_beats(30);
    drain();
    cfg_all(16'd1000, 16'd2000, 16'd500, 16'd1000, 16'd1001, 16'd10);
    random_beats(30);
    drain();
    // zero ranges collapse the clamp; upper data bits must be dropped
    cfg_all(16'd1000, 16'd2000, 16'hC014, 16'h8000, 16'd0, 16'h8000);
    random_beats(30);
    drain();
    cfg_all(16'd1000, 16'd2000, 16'd0, 16'd1, 16'd1, 16'd0);
    random_beats(30);
    drain();
    // write to an index past the register list must change nothing
    cfg_put(CFG_UNUSED, 16'd7);
    cfg_we <= 1'b0;
    @(posedge clk);
    random_beats(20);
    drain();
  endtask

  // Random settings, each with a batch of random beats.
  task automatic test_random_configs();
    logic [15:0] lo, hi;
    repeat (10) begin
      lo = 16'($urandom_range(30000));
      hi = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(lo + $urandom_range(30000, 2));
      cfg_all(lo, hi, 16'($urandom_range(9) == 0 ? $urandom : $urandom_range(300)),
              16'($urandom_range(9) == 0 ? $urandom : $urandom_range(32767, 1)),
              16'($urandom_range(9) == 0 ? $urandom : $urandom_range(65535, 1)),
              16'($urandom_range(4) == 0 ? $urandom : $urandom_range(200)));
      calm = ($urandom_range(3) == 0);
      random_beats(100);
      calm = 1'b0;
      drain();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    cfg_all(16'd1000, 16'd2000, 16'd20, 16'd1000, 16'd1000, 16'd50);
    calm = 1'b1;
    hold_left = 200;
    random_beats(80);
    calm = 1'b0;
    random_beats(40);
    drain();
  endtask

  initial begin
    pw_low = 16'd1000;
    pw_high = 16'd2000;
    stick_dead = 14'd20;
    drv_range = 15'd1000;
    out_thr_range = 16'd1000;
    drv_dead = 15'd50;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_edges();
    test_backpressure();
    test_random_configs();
    drain();
    if (errors == 0 && mix_expected.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### rc_channel_mixer_deadband.f
src/rcmd_pkg.sv
src/rcmd_div_cell.sv
src/rcmd_div_chain.sv
src/rc_channel_mixer_deadband.sv
tb/tb.sv
